// ===== src/pixel_block_hash_and_color_count_unit_macros.svh =====
// Assertion macros for the pixel block hash and color count unit
`ifndef PIXEL_BLOCK_HASH_AND_COLOR_COUNT_UNIT_MACROS_SVH
`define PIXEL_BLOCK_HASH_AND_COLOR_COUNT_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define PBH_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PBH_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define PBH_ASSERT(label, clk, rst, prop, msg)
`define PBH_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== src/pbh_pkg.sv =====
// Shared constants and token type for the pixel block hash and color count unit
package pbh_pkg;

  localparam int unsigned SeenDepth  = 256;
  localparam int unsigned ColorW     = 24;
  localparam int unsigned HashW      = 32;
  localparam int unsigned CountOutW  = 9;
  localparam logic [31:0] HashBasis  = 32'd2166136261;
  localparam logic [31:0] HashPrime  = 32'd16777619;

  typedef struct packed {
    logic              valid;
    logic [ColorW-1:0] color;
    logic              last;
    logic              done;
    logic              stored;
  } token_t;

endpackage

// ===== src/pbh_cell.sv =====
// One color cell of the distinct color chain
module pbh_cell (
  input  logic           clk,
  input  logic           rst,
  input  pbh_pkg::token_t tok_in,
  output pbh_pkg::token_t tok_out
);

  logic                      occ;
  logic [pbh_pkg::ColorW-1:0] color;
  logic                      hit;
  logic                      take;
  pbh_pkg::token_t           tok_next;

  always_comb begin
    hit  = occ && (color == tok_in.color);
    take = !occ && !tok_in.done;
    tok_next        = tok_in;
    tok_next.done   = tok_in.done | hit | take;
    tok_next.stored = tok_in.stored | take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ           <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
      if (tok_in.valid) begin
        if (tok_in.last) begin
          occ <= 1'b0;
        end else if (take) begin
          occ <= 1'b1;
        end
      end
    end
    if (tok_in.valid && take) begin
      color <= tok_in.color;
    end
    tok_out.color  <= tok_next.color;
    tok_out.last   <= tok_next.last;
    tok_out.done   <= tok_next.done;
    tok_out.stored <= tok_next.stored;
  end

endmodule

// ===== src/pbh_hash.sv =====
// Running 32-bit xor-multiply hash over the pixels of a block
module pbh_hash (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       beat,
  input  logic [pbh_pkg::ColorW-1:0] color,
  input  logic                       last,
  output logic [pbh_pkg::HashW-1:0]  final_hash
);

  logic [pbh_pkg::HashW-1:0] hash;
  logic [pbh_pkg::HashW-1:0] mixed;
  logic [pbh_pkg::HashW-1:0] prod;

  assign mixed = hash ^ {{(pbh_pkg::HashW - pbh_pkg::ColorW){1'b0}}, color};
  assign prod  = pbh_pkg::HashW'(mixed * pbh_pkg::HashPrime);

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= pbh_pkg::HashBasis;
    end else if (beat) begin
      hash <= last ? pbh_pkg::HashBasis : prod;
    end
  end

  always_ff @(posedge clk) begin
    if (beat && last) begin
      final_hash <= prod;
    end
  end

endmodule

// ===== src/pixel_block_hash_and_color_count_unit.sv =====
// Top level: block hash and distinct color count over a chain of color cells
//
//  channel  signals                                        direction
//  in       in_valid, in_stall, pixel_color, last_pixel    pixel beats in
//  out      out_valid, out_stall, block_hash,              one result beat
//           distinct_colors, table_overflow                per block
//
// Pixels inside a block are taken one per cycle; each walks the cell chain.
// A last pixel stalls input: its result beat is offered once the pixel has passed
// through every cell of the chain and the result registers, and the next pixel is
// taken only after the result beat has been accepted.
// Reset (rst, synchronous) empties all cells and restores the hash basis.
// A stalled result holds; input stays stalled for as long as it waits.
`include "pixel_block_hash_and_color_count_unit_macros.svh"

module pixel_block_hash_and_color_count_unit #(
  parameter int unsigned SEEN_DEPTH = pbh_pkg::SeenDepth
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pbh_pkg::ColorW-1:0]    pixel_color,
  input  logic                          last_pixel,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pbh_pkg::HashW-1:0]     block_hash,
  output logic [pbh_pkg::CountOutW-1:0] distinct_colors,
  output logic                          table_overflow
);

  localparam int unsigned CountW = $clog2(SEEN_DEPTH + 1);

  pbh_pkg::token_t tok [SEEN_DEPTH+1];
  logic            in_beat;
  logic            busy;
  logic [CountW-1:0] count;
  logic [CountW-1:0] count_next;
  logic              ovf;
  logic              ovf_next;
  logic [CountW-1:0] out_count;
  logic [CountW+pbh_pkg::CountOutW-1:0] count_ext;
  pbh_pkg::token_t   tail;

  assign in_stall = busy;
  assign in_beat  = in_valid && !busy;

  assign tok[0] = '{valid: in_beat, color: pixel_color, last: last_pixel,
                    done: 1'b0, stored: 1'b0};

  for (genvar i = 0; i < SEEN_DEPTH; i++) begin : g_cell
    pbh_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  pbh_hash u_hash (
    .clk        (clk),
    .rst        (rst),
    .beat       (in_beat),
    .color      (pixel_color),
    .last       (last_pixel),
    .final_hash (block_hash)
  );

  assign tail       = tok[SEEN_DEPTH];
  assign count_next = count + CountW'(tail.stored);
  assign ovf_next   = ovf | !tail.done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      count     <= '0;
      ovf       <= 1'b0;
    end else begin
      if (in_beat && last_pixel) begin
        busy <= 1'b1;
      end else if (out_valid && !out_stall) begin
        busy <= 1'b0;
      end
      if (tail.valid && tail.last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (tail.valid) begin
        if (tail.last) begin
          count <= '0;
          ovf   <= 1'b0;
        end else begin
          count <= count_next;
          ovf   <= ovf_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail.valid && tail.last) begin
      out_count      <= count_next;
      table_overflow <= ovf_next;
    end
  end

  assign count_ext       = {{pbh_pkg::CountOutW{1'b0}}, out_count};
  assign distinct_colors = count_ext[pbh_pkg::CountOutW-1:0];

  `PBH_ASSERT(a_result_while_busy, clk, rst, out_valid |-> busy, "result beat with no block open")
  `PBH_ASSERT(a_tail_last_busy, clk, rst, (tail.valid && tail.last) |-> busy, "block end reached chain tail while not busy")
  `PBH_ASSERT_NEVER(a_count_bound, clk, rst, count > CountW'(SEEN_DEPTH), "color count above table depth")
  `PBH_ASSERT(a_result_from_tail, clk, rst, $rose(out_valid) |-> $past(tail.valid && tail.last), "result beat without a block end at the tail")

endmodule

// ===== verif/tb_pixel_block_hash_and_color_count_unit.sv =====
// Testbench for the pixel block hash and distinct color count unit, checked against a predictor
`timescale 1ns / 100ps

module tb_pixel_block_hash_and_color_count_unit;
  import pbh_pkg::*;

  localparam int unsigned DrainCycles   = SeenDepth + 20;
  localparam int unsigned HoldOffCycles = 600;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned MaxShown      = 10;
  localparam logic [ColorW-1:0] ColorMax = {ColorW{1'b1}};

  typedef struct packed {
    logic [HashW-1:0]     hash;
    logic [CountOutW-1:0] count;
    logic                 ovf;
  } block_result_t;

  typedef struct packed {
    logic [ColorW-1:0]    color;
    logic                 last;
    logic                 typed;
    logic [HashW-1:0]     hash;
    logic [CountOutW-1:0] count;
    logic                 ovf;
  } pixel_row_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [ColorW-1:0]    pixel_color;
  logic                 last_pixel;
  logic                 out_valid;
  logic                 out_stall;
  logic [HashW-1:0]     block_hash;
  logic [CountOutW-1:0] distinct_colors;
  logic                 table_overflow;

  logic [HashW-1:0]  model_hash;
  logic [ColorW-1:0] model_colors [SeenDepth];
  int unsigned       model_count;
  bit                model_ovf;

  block_result_t pending_results [$];
  int unsigned   mismatches   = 0;
  int unsigned   beats_in     = 0;
  int unsigned   results_seen = 0;
  int unsigned   full_blocks  = 0;
  bit            calm         = 0;
  bit            hold_req     = 0;

  // single-pixel blocks of zero and the all-ones color, then blocks of repeats and alternating bits
  pixel_row_t directed_rows [18] = '{
    '{24'h000000, 1'b1, 1'b1, 32'h050c5d1f, 9'd1, 1'b0},
    '{ColorMax,   1'b1, 1'b0, '0, '0, 1'b0},
    '{24'h123456, 1'b0, 1'b0, '0, '0, 1'b0},
    '{24'h123456, 1'b0, 1'b0, '0, '0, 1'b0},
    '{24'h123456, 1'b0, 1'b0, '0, '0, 1'b0},
    '{24'h123456, 1'b1, 1'b0, '0, '0, 1'b0},
    '{24'h00ff00, 1'b0, 1'b0, '0, '0, 1'b0},
    '{24'hff0000, 1'b0, 1'b0, '0, '0, 1'b0},
    '{24'h00ff00, 1'b0, 1'b0, '0, '0, 1'b0},
    '{24'hff0000, 1'b1, 1'b0, '0, '0, 1'b0},
    '{24'h555555, 1'b0, 1'b0, '0, '0, 1'b0},
    '{24'haaaaaa, 1'b0, 1'b0, '0, '0, 1'b0},
    '{24'h000000, 1'b0, 1'b0, '0, '0, 1'b0},
    '{ColorMax,   1'b1, 1'b0, '0, '0, 1'b0},
    '{24'h800000, 1'b0, 1'b0, '0, '0, 1'b0},
    '{24'h000001, 1'b1, 1'b0, '0, '0, 1'b0},
    '{ColorMax,   1'b0, 1'b0, '0, '0, 1'b0},
    '{ColorMax,   1'b1, 1'b0, '0, '0, 1'b0}
  };

  pixel_block_hash_and_color_count_unit u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .pixel_color     (pixel_color),
    .last_pixel      (last_pixel),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .block_hash      (block_hash),
    .distinct_colors (distinct_colors),
    .table_overflow  (table_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_run();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic void clear_model();
    model_hash  = HashBasis;
    model_count = 0;
    model_ovf   = 1'b0;
  endfunction

  // hash step on the whole 24-bit color, then distinct-color bookkeeping
  function automatic void fold_pixel(input logic [ColorW-1:0] color);
    bit known;
    known = 1'b0;
    model_hash = (model_hash ^ {8'd0, color}) * HashPrime;
    for (int i = 0; i < model_count; i++)
      if (model_colors[i] == color) known = 1'b1;
    if (!known) begin
      if (model_count < SeenDepth) begin
        model_colors[model_count] = color;
        model_count++;
      end else begin
        model_ovf = 1'b1;
      end
    end
  endfunction

  function automatic void report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MaxShown) $display("%0t mismatch: %s", $time, msg);
  endfunction

  task automatic send_pixel(input logic [ColorW-1:0] color, input logic last,
                            input bit typed = 1'b0, input block_result_t typed_result = '0);
    int unsigned gap;
    block_result_t res;
    gap = calm ? 0 : pick_run();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    pixel_color <= color;
    last_pixel  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_in++;
    fold_pixel(color);
    if (last) begin
      res = '{model_hash, model_count[CountOutW-1:0], model_ovf};
      if (model_ovf) full_blocks++;
      pending_results.push_back(typed ? typed_result : res);
      clear_model();
    end
  endtask

  task automatic send_small_block();
    logic [ColorW-1:0] palette [4];
    logic [ColorW-1:0] c;
    int unsigned len;
    foreach (palette[k]) palette[k] = ColorW'($urandom_range(0, ColorMax));
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
    for (int n = 0; n < len; n++) begin
      if ($urandom_range(0, 1) == 0) c = palette[$urandom_range(0, 3)];
      else c = ColorW'($urandom_range(0, ColorMax));
      send_pixel(c, n == len - 1);
    end
  endtask

  // distinct colors carry their index in the top bits; repeats are sprinkled in
  task automatic send_wide_block(input int unsigned fresh, input int unsigned repeats);
    logic [ColorW-1:0] used [$];
    logic [ColorW-1:0] c;
    int unsigned k;
    int unsigned r;
    int unsigned total;
    k = 0;
    r = 0;
    total = fresh + repeats;
    for (int n = 0; n < total; n++) begin
      if (k < fresh && (r == repeats || used.size() == 0 || $urandom_range(0, 39) != 0)) begin
        c = {k[8:0], 15'($urandom_range(0, 32767))};
        used.push_back(c);
        k++;
      end else begin
        c = used[$urandom_range(0, used.size() - 1)];
        r++;
      end
      send_pixel(c, n == total - 1);
    end
  endtask

  initial begin : receiver
    int unsigned len;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk);
      end else if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        len = pick_run() + 1;
        repeat (len) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    block_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result hash %h count %0d ovf %b",
                                  block_hash, distinct_colors, table_overflow));
      end else begin
        want = pending_results.pop_front();
        if (block_hash !== want.hash || distinct_colors !== want.count ||
            table_overflow !== want.ovf)
          report_mismatch($sformatf(
            "result %0d: expected hash %h count %0d ovf %b, got hash %h count %0d ovf %b",
            results_seen, want.hash, want.count, want.ovf,
            block_hash, distinct_colors, table_overflow));
      end
    end
  end

  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("timeout: no beat moved for %0d cycles", WatchdogLimit);
    $display("FAIL pixel_block_hash_and_color_count_unit");
    $finish;
  end

  initial begin : stimulus
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    pixel_color <= '0;
    last_pixel  <= 1'b0;
    clear_model();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_pixel(directed_rows[i].color, directed_rows[i].last, directed_rows[i].typed,
                 '{directed_rows[i].hash, directed_rows[i].count, directed_rows[i].ovf});

    repeat (12) send_small_block();
    calm = 1'b1;
    send_wide_block(SeenDepth, 6);
    calm = 1'b0;
    hold_req = 1'b1;
    repeat (10) send_small_block();
    send_wide_block(SeenDepth + 6, 4);
    repeat (13) send_small_block();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d pixel beats and %0d block results, %0d of them with a full table",
             beats_in, results_seen, full_blocks);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS pixel_block_hash_and_color_count_unit");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("FAIL pixel_block_hash_and_color_count_unit");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/pbh_pkg.sv
src/pbh_cell.sv
src/pbh_hash.sv
src/pixel_block_hash_and_color_count_unit.sv
verif/tb_pixel_block_hash_and_color_count_unit.sv
